// ===== hdl/idalu_pkg.sv =====
// Shared request and response codes and controller state codes for the ID allocator.
package idalu_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] state_type;

   localparam op_type OP_CREATE  = 2'd0;
   localparam op_type OP_RELEASE = 2'd1;
   localparam op_type OP_LOOKUP  = 2'd2;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_NO_FREE    = 2'd1;
   localparam status_type ST_BAD_ID     = 2'd2;
   localparam status_type ST_STACK_FULL = 2'd3;

   localparam state_type S_IDLE   = 2'd0;
   localparam state_type S_POP    = 2'd1;
   localparam state_type S_LOOKUP = 2'd2;

endpackage

// ===== hdl/idalu_if.sv =====
// Request and response channel interfaces of the ID allocator.
interface idalu_req_if #(
   parameter int ID_W        = 11,
   parameter int HANDLE_BITS = 32
) ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             op;
   logic [HANDLE_BITS-1:0] handle_in;
   logic [ID_W-1:0]        id_in;

   modport source (output valid, op, handle_in, id_in, input ready);
   modport sink (input valid, op, handle_in, id_in, output ready);
endinterface

interface idalu_rsp_if #(
   parameter int ID_W        = 11,
   parameter int HANDLE_BITS = 32
) ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [ID_W-1:0]        id_out;
   logic [HANDLE_BITS-1:0] handle_out;

   modport source (output valid, status, id_out, handle_out, input ready);
   modport sink (input valid, status, id_out, handle_out, output ready);
endinterface

// ===== hdl/id_allocator_with_lookup_unit.sv =====
// Top level of the ID allocator: free-ID stack, handle table and request sequencer.
// Create of a fresh ID, release and every rejected item load their result into the result
// register as the item is accepted; create that reuses a freed ID and lookup first pass
// through a wait state (S_POP or S_LOOKUP) for a read of the free stack or handle table RAM.
// A new item is taken only in the idle state while the result register is empty or being read.
// Reset clears the sequencer, counters and result valid flag; the RAMs and result data are not cleared.
module id_allocator_with_lookup_unit
   import idalu_pkg::*;
#(
   parameter int MAX_IDS     = 1024,
   parameter int HANDLE_BITS = 32
) (
   input logic         clock,
   input logic         reset,
   idalu_req_if.sink   req_chan,
   idalu_rsp_if.source rsp_chan
);

   localparam int ID_W = $clog2(MAX_IDS + 1);
   localparam int AW   = $clog2(MAX_IDS);

   state_type              state_ff, state_in;
   logic [ID_W-1:0]        free_count_ff, free_count_in;
   logic [ID_W-1:0]        next_fresh_ff, next_fresh_in;
   logic [HANDLE_BITS-1:0] cur_handle_ff, cur_handle_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;

   logic                   accept;
   logic                   load_rsp;
   logic                   issued;
   logic [ID_W-1:0]        fc_dec;
   logic [ID_W-1:0]        nf_dec;
   logic [ID_W-1:0]        id_dec;
   logic [ID_W-1:0]        pop_dec;

   logic                   stk_wr_en;
   logic [AW-1:0]          stk_wr_addr;
   logic [ID_W-1:0]        stk_wr_data;
   logic                   stk_rd_en;
   logic [AW-1:0]          stk_rd_addr;
   logic [ID_W-1:0]        stk_rd_data;

   logic                   tbl_wr_en;
   logic [AW-1:0]          tbl_wr_addr;
   logic [HANDLE_BITS-1:0] tbl_wr_data;
   logic                   tbl_rd_en;
   logic [AW-1:0]          tbl_rd_addr;
   logic [HANDLE_BITS-1:0] tbl_rd_data;

   idalu_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   idalu_ram #(.WIDTH(HANDLE_BITS), .DEPTH(MAX_IDS)) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign fc_dec  = free_count_ff - ID_W'(1);
   assign nf_dec  = next_fresh_ff - ID_W'(1);
   assign id_dec  = req_chan.id_in - ID_W'(1);
   assign pop_dec = stk_rd_data - ID_W'(1);
   assign issued  = (req_chan.id_in != '0) && (req_chan.id_in < next_fresh_ff);

   always_comb begin
      state_in      = state_ff;
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      cur_handle_in = cur_handle_ff;
      load_rsp      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_id_in     = '0;
      rsp_handle_in = '0;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = free_count_ff[AW-1:0];
      stk_wr_data   = req_chan.id_in;
      stk_rd_en     = 1'b0;
      stk_rd_addr   = fc_dec[AW-1:0];
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = nf_dec[AW-1:0];
      tbl_wr_data   = req_chan.handle_in;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = id_dec[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.op)
                  OP_CREATE: begin
                     if (free_count_ff != '0) begin
                        free_count_in = fc_dec;
                        stk_rd_en     = 1'b1;
                        cur_handle_in = req_chan.handle_in;
                        state_in      = S_POP;
                     end else if (next_fresh_ff <= ID_W'(MAX_IDS)) begin
                        tbl_wr_en     = 1'b1;
                        next_fresh_in = next_fresh_ff + ID_W'(1);
                        load_rsp      = 1'b1;
                        rsp_id_in     = next_fresh_ff;
                     end else begin
                        load_rsp      = 1'b1;
                        rsp_status_in = ST_NO_FREE;
                     end
                  end
                  OP_RELEASE: begin
                     load_rsp = 1'b1;
                     if (!issued) begin
                        rsp_status_in = ST_BAD_ID;
                     end else if (free_count_ff >= ID_W'(MAX_IDS)) begin
                        rsp_status_in = ST_STACK_FULL;
                     end else begin
                        stk_wr_en     = 1'b1;
                        free_count_in = free_count_ff + ID_W'(1);
                     end
                  end
                  OP_LOOKUP: begin
                     if (issued) begin
                        tbl_rd_en = 1'b1;
                        state_in  = S_LOOKUP;
                     end else begin
                        load_rsp      = 1'b1;
                        rsp_status_in = ST_BAD_ID;
                     end
                  end
                  default: begin
                     load_rsp      = 1'b1;
                     rsp_status_in = ST_BAD_ID;
                  end
               endcase
            end
         end
         S_POP: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = pop_dec[AW-1:0];
            tbl_wr_data = cur_handle_ff;
            load_rsp    = 1'b1;
            rsp_id_in   = stk_rd_data;
            state_in    = S_IDLE;
         end
         S_LOOKUP: begin
            load_rsp      = 1'b1;
            rsp_handle_in = tbl_rd_data;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= '0;
         next_fresh_ff <= ID_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_handle_ff <= cur_handle_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_handle_ff <= rsp_handle_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.id_out     = rsp_id_ff;
   assign rsp_chan.handle_out = rsp_handle_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= ID_W'(MAX_IDS))
      else $error("Free stack count exceeds the number of IDs.");

   a_fresh_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_fresh_ff != '0)
      else $error("Fresh ID counter reached zero.");

   a_wait_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("Result register occupied while a memory read is pending.");

   a_fail_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_id_ff == '0 && rsp_handle_ff == '0))
      else $error("Rejected item carries an ID or handle.");

endmodule

// ===== hdl/idalu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module idalu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/id_allocator_with_lookup_unit_tb.sv =====
// Self-checking testbench for the ID allocator: create, release, lookup and unused-op items checked per reply.
module id_allocator_with_lookup_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import idalu_pkg::*;

   localparam int MAX_IDS      = 1024;
   localparam int HANDLE_BITS  = 32;
   localparam int ID_W         = 11;
   localparam int RANDOM_ITEMS = 550;
   localparam int PHASE_LEN    = 128;
   localparam int HOLD_AT      = 30;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int REPORT_MAX   = 10;

   localparam op_type OP_UNUSED = 2'd3;

   localparam int PH_STEADY      = 0;
   localparam int PH_SEND_GAPS   = 1;
   localparam int PH_RECV_STALLS = 2;
   localparam int PH_BOTH        = 3;

   typedef struct packed {
      op_type                 op;
      logic [HANDLE_BITS-1:0] handle;
      logic [ID_W-1:0]        id;
   } request_type;

   typedef struct packed {
      status_type             status;
      logic [ID_W-1:0]        id;
      logic [HANDLE_BITS-1:0] handle;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   idalu_req_if #(.ID_W(ID_W), .HANDLE_BITS(HANDLE_BITS)) req_chan ();
   idalu_rsp_if #(.ID_W(ID_W), .HANDLE_BITS(HANDLE_BITS)) rsp_chan ();

   id_allocator_with_lookup_unit #(
      .MAX_IDS     (MAX_IDS),
      .HANDLE_BITS (HANDLE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [ID_W-1:0]        fresh_id   = 1;
   logic [ID_W-1:0]        free_depth = 0;
   logic [ID_W-1:0]        free_ids     [0:MAX_IDS-1];
   logic [HANDLE_BITS-1:0] handle_store [1:MAX_IDS];

   request_type queued_requests[$];
   reply_type   awaited_replies[$];
   request_type next_request;
   request_type taken_request;
   reply_type   want_reply;
   reply_type   seen_reply;

   int requests_taken = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   function automatic reply_type apply_request(request_type rq);
      reply_type rp;
      logic      known;
      rp = '0;
      rp.status = ST_OK;
      known = rq.id != 0 && rq.id < fresh_id && rq.id <= MAX_IDS;
      case (rq.op)
         OP_CREATE: begin
            if (free_depth != 0) begin
               free_depth = free_depth - 1'b1;
               rp.id = free_ids[free_depth];
            end else if (fresh_id <= MAX_IDS) begin
               rp.id = fresh_id;
               fresh_id = fresh_id + 1'b1;
            end else begin
               rp.status = ST_NO_FREE;
            end
            if (rp.status == ST_OK) begin
               handle_store[rp.id] = rq.handle;
            end
         end
         OP_RELEASE: begin
            if (!known) begin
               rp.status = ST_BAD_ID;
            end else if (free_depth >= MAX_IDS) begin
               rp.status = ST_STACK_FULL;
            end else begin
               free_ids[free_depth] = rq.id;
               free_depth = free_depth + 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (known) begin
               rp.handle = handle_store[rq.id];
            end else begin
               rp.status = ST_BAD_ID;
            end
         end
         default: begin
            rp.status = ST_BAD_ID;
         end
      endcase
      return rp;
   endfunction

   function automatic int idle_phase();
      return (requests_taken / PHASE_LEN) % 4;
   endfunction

   function automatic bit sender_pauses();
      int ph;
      ph = idle_phase();
      if (ph == PH_SEND_GAPS) return $urandom_range(99) < 66;
      if (ph == PH_BOTH) return $urandom_range(99) < 22;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      int ph;
      ph = idle_phase();
      if (ph == PH_RECV_STALLS) return $urandom_range(99) < 66;
      if (ph == PH_BOTH) return $urandom_range(99) < 22;
      return 1'b0;
   endfunction

   function automatic logic [ID_W-1:0] random_issued_id();
      logic [ID_W-1:0] top;
      top = fresh_id - 1'b1;
      if (top == 0) return ID_W'($urandom_range(2**ID_W - 1));
      if ($urandom_range(3) == 0) return top;
      return ID_W'($urandom_range(1, top));
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int unsigned pick;
      rq.op = OP_CREATE;
      rq.handle = $urandom;
      rq.id = ID_W'($urandom_range(2**ID_W - 1));
      pick = $urandom_range(9);
      if (pick == 0) rq.handle = '0;
      else if (pick == 1) rq.handle = '1;
      pick = $urandom_range(99);
      if (pick < 35) begin
         rq.op = OP_CREATE;
      end else if (pick < 60) begin
         rq.op = OP_RELEASE;
         rq.id = random_issued_id();
      end else if (pick < 90) begin
         rq.op = OP_LOOKUP;
         rq.id = random_issued_id();
      end else begin
         rq.op = op_type'($urandom_range(3));
         if ($urandom_range(1) == 0) rq.id = ID_W'(fresh_id + $urandom_range(20));
      end
      return rq;
   endfunction

   task automatic queue_request(input op_type code, input logic [HANDLE_BITS-1:0] hnd,
                                input logic [ID_W-1:0] ident);
      request_type rq;
      rq.op = code;
      rq.handle = hnd;
      rq.id = ident;
      while (queued_requests.size() >= 4) @(posedge clock);
      queued_requests.push_back(rq);
   endtask

   function automatic void report_mismatch(string what, reply_type want, reply_type got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("%0t %s: expected status %0d id %0d handle %h, got status %0d id %0d handle %h",
                  $realtime, what, want.status, want.id, want.handle,
                  got.status, got.id, got.handle);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            taken_request.op = req_chan.op;
            taken_request.handle = req_chan.handle_in;
            taken_request.id = req_chan.id_in;
            awaited_replies.push_back(apply_request(taken_request));
            requests_taken <= requests_taken + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (queued_requests.size() != 0 && !sender_pauses()) begin
               next_request = queued_requests.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.op <= next_request.op;
               req_chan.handle_in <= next_request.handle;
               req_chan.id_in <= next_request.id;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!hold_done && requests_taken >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_reply.status = rsp_chan.status;
            seen_reply.id = rsp_chan.id_out;
            seen_reply.handle = rsp_chan.handle_out;
            if (awaited_replies.size() == 0) begin
               report_mismatch("reply with none awaited", '0, seen_reply);
            end else begin
               want_reply = awaited_replies.pop_front();
               if (want_reply.status !== seen_reply.status || want_reply.id !== seen_reply.id ||
                   want_reply.handle !== seen_reply.handle) begin
                  report_mismatch("reply mismatch", want_reply, seen_reply);
               end
            end
         end
         rsp_chan.ready <= hold_left == 0 && !receiver_stalls();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("id_allocator_with_lookup_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      int n;
      req_chan.valid = 1'b0;
      req_chan.op = OP_CREATE;
      req_chan.handle_in = '0;
      req_chan.id_in = '0;
      rsp_chan.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_request(OP_LOOKUP, '0, 0);
      queue_request(OP_RELEASE, '1, 0);
      queue_request(OP_LOOKUP, '0, 1);
      queue_request(OP_RELEASE, '0, 1);
      queue_request(OP_CREATE, '0, 0);
      queue_request(OP_LOOKUP, '0, 1);
      queue_request(OP_CREATE, '1, 2047);
      queue_request(OP_LOOKUP, '0, 2);
      queue_request(OP_CREATE, 32'h5a5a_a5a5, 0);
      queue_request(OP_RELEASE, '0, 2);
      queue_request(OP_RELEASE, '0, 2);
      queue_request(OP_LOOKUP, '0, 2);
      queue_request(OP_CREATE, 32'h1234_5678, 0);
      queue_request(OP_CREATE, 32'h9abc_def0, 0);
      queue_request(OP_LOOKUP, '0, 2);
      queue_request(OP_UNUSED, '1, 2047);
      queue_request(OP_LOOKUP, '1, 2047);
      queue_request(OP_RELEASE, '0, MAX_IDS);
      queue_request(OP_LOOKUP, '0, 4);
      queue_request(OP_RELEASE, '0, 3);
      queue_request(OP_CREATE, 32'hc0de_0003, 0);
      queue_request(OP_LOOKUP, '0, 3);
      queue_request(OP_RELEASE, '0, 1);
      queue_request(OP_LOOKUP, '0, 1);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         while (queued_requests.size() >= 4) @(posedge clock);
         queued_requests.push_back(random_request());
      end

      do @(posedge clock);
      while (queued_requests.size() != 0 || req_chan.valid || awaited_replies.size() != 0);
      repeat (8) @(posedge clock);
      if (error_count == 0 && awaited_replies.size() == 0) begin
         $display("id_allocator_with_lookup_unit_tb: clean");
      end else begin
         $display("id_allocator_with_lookup_unit_tb: errors");
      end
      $finish;
   end

endmodule
